>>> hw/rtl/svacc_pkg.sv
// shared types and codes for the sparse vector accumulator
`timescale 1ns / 1ps

package svacc_pkg;

  // operation selector carried in the input tuser
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // result status codes carried in the output tuser
  localparam logic [2:0] STAT_ZERO     = 3'd0;
  localparam logic [2:0] STAT_MERGED   = 3'd1;
  localparam logic [2:0] STAT_REMOVED  = 3'd2;
  localparam logic [2:0] STAT_APPENDED = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;
  localparam logic [2:0] STAT_READ_OK  = 3'd5;
  localparam logic [2:0] STAT_READ_OOR = 3'd6;
  localparam logic [2:0] STAT_CLEARED  = 3'd7;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_HIT,
    WR_APPEND,
    WR_SHIFT
  } wr_sel_e;

  typedef enum logic [3:0] {
    RES_NONE,
    RES_ZERO_ADD,
    RES_NOP,
    RES_READ_OOR,
    RES_CLEAR,
    RES_MERGE,
    RES_REMOVE,
    RES_APPEND,
    RES_FULL,
    RES_READ
  } res_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     ptr_clr;
    logic     step;
    logic     capture;
    logic     ptr_from_pos;
    logic     rd_rpos;
    wr_sel_e  wr_sel;
    cnt_op_e  cnt_op;
    res_sel_e res_sel;
    logic     out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       addv_zero;
    logic       cnt_zero;
    logic       cnt_full;
    logic       rpos_ok;
    logic       cmp_vld;
    logic       hit;
    logic       cmp_last;
    logic       sum_zero;
    logic       pos_last;
  } dp_sts_t;

endpackage

>>> hw/rtl/svacc_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module svacc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/svacc_datapath.sv
// datapath: list storage, scan pointers, saturating adder, result registers
`timescale 1ns / 1ps

module svacc_datapath #(
  parameter int CAPACITY    = 64,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  svacc_pkg::dp_cmd_t   cmd_i,
  output svacc_pkg::dp_sts_t   sts_o,
  input  logic [1:0]           mode_i,
  input  logic [15:0]          coef_index_i,
  input  logic [31:0]          coef_value_i,
  input  logic [5:0]           read_position_i,
  output logic [2:0]           status_o,
  output logic [15:0]          entry_index_o,
  output logic [31:0]          entry_value_o,
  output logic [5:0]           entry_position_o,
  output logic [6:0]           entry_count_o
);

  import svacc_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CmpW  = (CW > 6) ? CW : 6;
  localparam int KeyW  = (INDEX_WIDTH < 16) ? INDEX_WIDTH : 16;
  localparam int RamW  = KeyW + 32;

  logic [1:0]      mode_q;
  logic [KeyW-1:0] key_q;
  logic [31:0]     addv_q;
  logic [5:0]      rpos_q;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   cmp_pos_q, cmp_pos_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [CW-1:0]   pos_q;
  logic [31:0]     sum_q;
  logic [CW-1:0]   count_q, count_d;

  logic [2:0]      res_status_q, res_status_d;
  logic [15:0]     res_index_q, res_index_d;
  logic [31:0]     res_value_q, res_value_d;
  logic [5:0]      res_pos_q, res_pos_d;

  logic [2:0]      out_status_q;
  logic [15:0]     out_index_q;
  logic [31:0]     out_value_q;
  logic [5:0]      out_pos_q;
  logic [6:0]      out_count_q;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [RamW-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [RamW-1:0] ram_rdata;
  logic [KeyW-1:0] rd_key;
  logic [31:0]     rd_val;
  logic [32:0]     sum_wide;
  logic [31:0]     sum_sat;
  logic [CW-1:0]   count_m1;

  assign rd_key   = ram_rdata[RamW-1:32];
  assign rd_val   = ram_rdata[31:0];
  assign count_m1 = count_q - CW'(1);

  // saturating q16.16 add of stored value and coefficient
  assign sum_wide = {rd_val[31], rd_val} + {addv_q[31], addv_q};
  always_comb begin
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  // ram ports
  assign ram_raddr = cmd_i.rd_rpos ? AW'(rpos_q) : AW'(ptr_q);

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = AW'(pos_q);
    ram_wdata = {key_q, sum_q};
    case (cmd_i.wr_sel)
      WR_HIT: begin
        ram_waddr = AW'(pos_q);
        ram_wdata = {key_q, sum_q};
      end
      WR_APPEND: begin
        ram_waddr = AW'(count_q);
        ram_wdata = {key_q, addv_q};
      end
      WR_SHIFT: begin
        ram_waddr = AW'(cmp_pos_q - CW'(1));
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  svacc_ram #(
    .WIDTH(RamW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // scan / shift pointers
  always_comb begin
    ptr_d     = ptr_q;
    cmp_pos_d = cmp_pos_q;
    cmp_vld_d = cmp_vld_q;
    if (cmd_i.ptr_clr) begin
      ptr_d     = '0;
      cmp_vld_d = 1'b0;
    end else if (cmd_i.ptr_from_pos) begin
      ptr_d     = pos_q + CW'(1);
      cmp_vld_d = 1'b0;
    end else if (cmd_i.step) begin
      ptr_d     = ptr_q + CW'(1);
      cmp_pos_d = ptr_q;
      cmp_vld_d = 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    case (cmd_i.cnt_op)
      CNT_CLEAR: count_d = '0;
      CNT_INC:   count_d = count_q + CW'(1);
      CNT_DEC:   count_d = count_m1;
      default:   count_d = count_q;
    endcase
  end

  always_comb begin
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_value_d  = res_value_q;
    res_pos_d    = res_pos_q;
    case (cmd_i.res_sel)
      RES_ZERO_ADD: begin
        res_status_d = STAT_ZERO;
        res_index_d  = 16'(key_q);
        res_value_d  = '0;
        res_pos_d    = '0;
      end
      RES_NOP: begin
        res_status_d = STAT_ZERO;
        res_index_d  = '0;
        res_value_d  = '0;
        res_pos_d    = '0;
      end
      RES_READ_OOR: begin
        res_status_d = STAT_READ_OOR;
        res_index_d  = '0;
        res_value_d  = '0;
        res_pos_d    = rpos_q;
      end
      RES_CLEAR: begin
        res_status_d = STAT_CLEARED;
        res_index_d  = '0;
        res_value_d  = '0;
        res_pos_d    = '0;
      end
      RES_MERGE: begin
        res_status_d = STAT_MERGED;
        res_index_d  = 16'(key_q);
        res_value_d  = sum_q;
        res_pos_d    = 6'(pos_q);
      end
      RES_REMOVE: begin
        res_status_d = STAT_REMOVED;
        res_index_d  = 16'(key_q);
        res_value_d  = '0;
        res_pos_d    = 6'(pos_q);
      end
      RES_APPEND: begin
        res_status_d = STAT_APPENDED;
        res_index_d  = 16'(key_q);
        res_value_d  = addv_q;
        res_pos_d    = 6'(count_q);
      end
      RES_FULL: begin
        res_status_d = STAT_FULL;
        res_index_d  = 16'(key_q);
        res_value_d  = addv_q;
        res_pos_d    = '0;
      end
      RES_READ: begin
        res_status_d = STAT_READ_OK;
        res_index_d  = 16'(rd_key);
        res_value_d  = rd_val;
        res_pos_d    = rpos_q;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    cmp_pos_q    <= cmp_pos_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_value_q  <= res_value_d;
    res_pos_q    <= res_pos_d;
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q  <= coef_index_i[KeyW-1:0];
      addv_q <= coef_value_i;
      rpos_q <= read_position_i;
    end
    if (cmd_i.capture) begin
      pos_q <= cmp_pos_q;
      sum_q <= sum_sat;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_value_q  <= res_value_q;
      out_pos_q    <= res_pos_q;
      out_count_q  <= 7'(count_q);
    end
  end

  always_comb begin
    sts_o.mode      = mode_q;
    sts_o.addv_zero = (addv_q == '0);
    sts_o.cnt_zero  = (count_q == '0);
    sts_o.cnt_full  = (count_q >= CW'(CAPACITY));
    sts_o.rpos_ok   = (CmpW'(rpos_q) < CmpW'(count_q));
    sts_o.cmp_vld   = cmp_vld_q;
    sts_o.hit       = (rd_key == key_q);
    sts_o.cmp_last  = (cmp_pos_q == count_m1);
    sts_o.sum_zero  = (sum_q == '0);
    sts_o.pos_last  = (pos_q == count_m1);
  end

  assign status_o         = out_status_q;
  assign entry_index_o    = out_index_q;
  assign entry_value_o    = out_value_q;
  assign entry_position_o = out_pos_q;
  assign entry_count_o    = out_count_q;

endmodule

>>> hw/rtl/svacc_ctrl.sv
// controller state machine sequencing search, merge, shift and append
`timescale 1ns / 1ps

module svacc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output svacc_pkg::dp_cmd_t cmd_o,
  input  svacc_pkg::dp_sts_t sts_i
);

  import svacc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_MERGE,
    ST_SHIFT,
    ST_APPEND,
    ST_RDWAIT,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{
      load:         1'b0,
      ptr_clr:      1'b0,
      step:         1'b0,
      capture:      1'b0,
      ptr_from_pos: 1'b0,
      rd_rpos:      1'b0,
      wr_sel:       WR_NONE,
      cnt_op:       CNT_KEEP,
      res_sel:      RES_NONE,
      out_load:     1'b0
    };

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.mode)
          MODE_ADD: begin
            if (sts_i.addv_zero) begin
              cmd_o.res_sel = RES_ZERO_ADD;
              state_d       = ST_RESP;
            end else if (sts_i.cnt_zero) begin
              state_d = ST_APPEND;
            end else begin
              cmd_o.ptr_clr = 1'b1;
              state_d       = ST_SCAN;
            end
          end
          MODE_READ: begin
            if (sts_i.rpos_ok) begin
              cmd_o.rd_rpos = 1'b1;
              state_d       = ST_RDWAIT;
            end else begin
              cmd_o.res_sel = RES_READ_OOR;
              state_d       = ST_RESP;
            end
          end
          MODE_CLEAR: begin
            cmd_o.cnt_op  = CNT_CLEAR;
            cmd_o.res_sel = RES_CLEAR;
            state_d       = ST_RESP;
          end
          default: begin
            cmd_o.res_sel = RES_NOP;
            state_d       = ST_RESP;
          end
        endcase
      end
      ST_SCAN: begin
        // one read issued per cycle; the compare works on the registered read data and the registered address (cmp_pos)
        if (sts_i.cmp_vld && sts_i.hit) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MERGE;
        end else if (sts_i.cmp_vld && sts_i.cmp_last) begin
          state_d = ST_APPEND;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_MERGE: begin
        if (sts_i.sum_zero) begin
          cmd_o.res_sel = RES_REMOVE;
          if (sts_i.pos_last) begin
            cmd_o.cnt_op = CNT_DEC;
            state_d      = ST_RESP;
          end else begin
            cmd_o.ptr_from_pos = 1'b1;
            state_d            = ST_SHIFT;
          end
        end else begin
          cmd_o.wr_sel  = WR_HIT;
          cmd_o.res_sel = RES_MERGE;
          state_d       = ST_RESP;
        end
      end
      ST_SHIFT: begin
        // read entry n while slot n-2 takes the registered read data of entry n-1
        cmd_o.step = 1'b1;
        if (sts_i.cmp_vld) begin
          cmd_o.wr_sel = WR_SHIFT;
          if (sts_i.cmp_last) begin
            cmd_o.cnt_op = CNT_DEC;
            state_d      = ST_RESP;
          end
        end
      end
      ST_APPEND: begin
        if (sts_i.cnt_full) begin
          cmd_o.res_sel = RES_FULL;
        end else begin
          cmd_o.wr_sel  = WR_APPEND;
          cmd_o.res_sel = RES_APPEND;
          cmd_o.cnt_op  = CNT_INC;
        end
        state_d = ST_RESP;
      end
      ST_RDWAIT: begin
        cmd_o.res_sel = RES_READ;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/sparse_vector_accumulator.sv
// sparse_vector_accumulator: ordered (index, value) list with saturating accumulate
//
// Input stream (s_axis): tuser carries the mode (add, read, clear), tdata the
// coefficient index, the signed q16.16 coefficient and the read position.
// Output stream (m_axis): exactly one result transaction per input transaction;
// tuser carries the status, tdata the entry index, value, position and count.
// Items are worked one at a time. An add searches the list one entry per clock
// through a single ram read port and appends a new index behind the last
// entry. A sum of exactly zero removes the entry and moves every later entry
// down one place, one entry per cycle. Reads, clears, zero adds and the
// unused mode 3 skip the search. The next item is accepted in the cycle after
// the result is loaded into the output register, so a stalled receiver holds
// at most one finished result and blocks the next result, not the next accept.
// Reset empties the list at once (count to zero); no clearing pass runs.
`timescale 1ns / 1ps

module sparse_vector_accumulator #(
  parameter int CAPACITY    = 64,
  parameter int INDEX_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // coef_index[15:0], coef_value[47:16], read_position[53:48], zero fill
  input  logic [55:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // entry_index[15:0], entry_value[47:16], entry_position[53:48],
  // entry_count[60:54], zero fill
  output logic [63:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser
);

  import svacc_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [15:0] entry_index;
  logic [31:0] entry_value;
  logic [5:0]  entry_position;
  logic [6:0]  entry_count;

  svacc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  svacc_datapath #(
    .CAPACITY   (CAPACITY),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (s_axis_tuser),
    .coef_index_i    (s_axis_tdata[15:0]),
    .coef_value_i    (s_axis_tdata[47:16]),
    .read_position_i (s_axis_tdata[53:48]),
    .status_o        (m_axis_tuser),
    .entry_index_o   (entry_index),
    .entry_value_o   (entry_value),
    .entry_position_o(entry_position),
    .entry_count_o   (entry_count)
  );

  assign m_axis_tdata = {3'b000, entry_count, entry_position, entry_value, entry_index};

endmodule
